/* hdl/dot_pkg.sv */
// Shared types, constants and helper functions of the odometry tracker.
package dot_pkg;

    localparam int COUNT_BITS    = 32;
    localparam int POS_FRAC_BITS = 16;
    localparam int CORDIC_STEPS  = 20;

    localparam int DLT_W   = 33;
    localparam int NUM_W   = DLT_W - 1 + 24;
    localparam int ANG_W   = 36;
    localparam int RED_W   = 38;
    localparam int XY_W    = 34;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int POS_W   = 48;
    localparam int HEAD_W  = 32;
    localparam int RND_SH  = 29 - POS_FRAC_BITS;
    localparam int ROT_N   = (CORDIC_STEPS < 28) ? CORDIC_STEPS : 28;

    localparam logic [RED_W-1:0] ANG_TWO_PI = RED_W'(64'd6746518852);
    localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(64'sd3373259426);
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(64'sd1686629713);
    localparam logic signed [XY_W-1:0]  CORDIC_INV_GAIN = XY_W'(64'sd652032874);

    localparam logic signed [63:0] CNT_HI = (64'sd1 <<< (COUNT_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] CNT_LO = -CNT_HI - 64'sd1;

    localparam int ENC_LEFT   = 0;
    localparam int ENC_RIGHT  = 1;
    localparam int ENC_STRAFE = 2;

    localparam logic [1:0] REG_TRACK_WIDTH = 2'd0;
    localparam logic [1:0] REG_ENC_ENABLE  = 2'd1;

    typedef struct packed {
        logic signed [DLT_W-1:0] dl;
        logic signed [DLT_W-1:0] dr;
        logic signed [DLT_W-1:0] ds;
        logic signed [DLT_W-1:0] diff;
    } t_tick;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_HEAD, ST_MID, ST_RED, ST_FOLD,
        ST_ROT, ST_CS, ST_MUL, ST_RND, ST_OUT
    } t_back_state;

    function automatic logic signed [DLT_W-1:0] sat_count(input logic signed [DLT_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (w > CNT_HI) return DLT_W'(CNT_HI);
        else if (w < CNT_LO) return DLT_W'(CNT_LO);
        else return v;
    endfunction

    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [ANG_W-1:0] r;
        unique case (i)
            5'd0:  r = ANG_W'(843314857);
            5'd1:  r = ANG_W'(497837830);
            5'd2:  r = ANG_W'(263043837);
            5'd3:  r = ANG_W'(133525159);
            5'd4:  r = ANG_W'(67021688);
            5'd5:  r = ANG_W'(33543516);
            5'd6:  r = ANG_W'(16775852);
            5'd7:  r = ANG_W'(8388438);
            5'd8:  r = ANG_W'(4194283);
            5'd9:  r = ANG_W'(2097149);
            default: r = ANG_W'(64'sd1 <<< (30 - i));
        endcase
        return r;
    endfunction

endpackage

/* hdl/drive_odometry_tracker.sv */
// Top level of the differential-drive odometry tracker.
// Usage:
//  Slave stream takes one tracking tick per word: tdata holds the absolute
//  left, right and strafe encoder counts. Master stream returns one word per
//  tick with global X, Y (Q32.16) and the absolute heading (Q8.24 radians).
//  The configuration port writes track_width (index 0) and encoder_enable
//  (index 1); write only while no tick is in flight.
//  The back end runs the bit-serial heading divider and the 20-step CORDIC
//  loop; ticks are processed one at a time.
//  A two-word queue behind the input lets up to two ticks be taken while the
//  back end works; tready drops when it is full.
//  The result sits in an output register; while the receiver stalls the back
//  end holds its finished tick and the queue keeps filling.
//  Reset clears position, heading and last counts to zero, sets track_width
//  to 1 and enables all three encoders.
module drive_odometry_tracker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [95:0]   i_s_axis_tdata,  // left_count, right_count, strafe_count
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [127:0]  o_m_axis_tdata,  // pos_x, pos_y, heading_angle
    input  logic          i_cfg_wr_en,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);
    import dot_pkg::*;

    logic [15:0] r_track_width;
    logic [2:0]  r_enc_en;
    logic        push, pop, q_full, q_empty;
    t_tick       f_tick, q_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_width <= 16'd1;
            r_enc_en      <= 3'd7;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == REG_TRACK_WIDTH) r_track_width <= i_cfg_data;
            else if (i_cfg_index == REG_ENC_ENABLE) r_enc_en <= i_cfg_data[2:0];
        end
    end

    dot_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_enc_en (r_enc_en),
        .i_valid  (i_s_axis_tvalid),
        .i_data   (i_s_axis_tdata),
        .i_q_full (q_full),
        .o_ready  (o_s_axis_tready),
        .o_push   (push),
        .o_tick   (f_tick)
    );

    dot_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tick  (f_tick),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_tick  (q_tick)
    );

    dot_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_track_width (r_track_width),
        .i_q_empty     (q_empty),
        .i_tick        (q_tick),
        .o_pop         (pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_data        (o_m_axis_tdata)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push) else $error("tick queue overflow");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty) else $error("pop from empty tick queue");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid) else $error("result valid after reset");

endmodule

/* hdl/dot_front.sv */
// Front end: takes encoder words, forms saturated deltas and the wheel difference.
module dot_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [2:0]           i_enc_en,
    input  logic                 i_valid,
    input  logic [95:0]          i_data,
    input  logic                 i_q_full,
    output logic                 o_ready,
    output logic                 o_push,
    output dot_pkg::t_tick       o_tick
);
    import dot_pkg::*;

    logic signed [31:0] r_last_l, r_last_r, r_last_s;
    logic signed [31:0] n_last_l, n_last_r, n_last_s;
    logic signed [31:0] v_l, v_r, v_s;

    assign v_l = i_data[31:0];
    assign v_r = i_data[63:32];
    assign v_s = i_data[95:64];

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        n_last_l = i_enc_en[ENC_LEFT]   ? v_l : r_last_l;
        n_last_r = i_enc_en[ENC_RIGHT]  ? v_r : r_last_r;
        n_last_s = i_enc_en[ENC_STRAFE] ? v_s : r_last_s;
        o_tick.dl = i_enc_en[ENC_LEFT]
                  ? sat_count(DLT_W'(v_l) - DLT_W'(r_last_l)) : '0;
        o_tick.dr = i_enc_en[ENC_RIGHT]
                  ? sat_count(DLT_W'(v_r) - DLT_W'(r_last_r)) : '0;
        o_tick.ds = i_enc_en[ENC_STRAFE]
                  ? sat_count(DLT_W'(v_s) - DLT_W'(r_last_s)) : '0;
        o_tick.diff = DLT_W'(n_last_r) - DLT_W'(n_last_l);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_l <= '0;
            r_last_r <= '0;
            r_last_s <= '0;
        end else if (o_push) begin
            r_last_l <= n_last_l;
            r_last_r <= n_last_r;
            r_last_s <= n_last_s;
        end
    end
endmodule

/* hdl/dot_queue.sv */
// Two-entry queue of tick deltas between front and back end.
module dot_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dot_pkg::t_tick i_tick,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output dot_pkg::t_tick o_tick
);
    import dot_pkg::*;

    t_tick      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_tick  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_tick;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

/* hdl/dot_back.sv */
// Back end: heading divide, angle reduction, CORDIC, rotation and accumulation.
module dot_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [15:0]    i_track_width,
    input  logic           i_q_empty,
    input  dot_pkg::t_tick i_tick,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [127:0]   o_data
);
    import dot_pkg::*;

    t_back_state r_st, n_st;

    logic signed [MUL_A_W-1:0] r_sum, r_ds2;
    logic                      r_neg;
    logic [NUM_W-1:0]          r_num;
    logic [16:0]               r_rem;
    logic [5:0]                r_cnt;
    logic signed [HEAD_W-1:0]  r_head, r_prev;
    logic                      r_red_neg;
    logic [RED_W-1:0]          r_red;
    logic signed [ANG_W-1:0]   r_ang;
    logic                      r_flip;
    logic signed [XY_W-1:0]    r_x, r_y;
    logic signed [MUL_B_W-1:0] r_cos, r_sin;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_px, r_py;
    logic signed [POS_W-1:0]   r_acc_x, r_acc_y;
    logic                      r_out_v;
    logic [127:0]              r_out;

    logic [15:0]               w;
    logic [17:0]               rem_t;
    logic                      ge;
    logic signed [NUM_W:0]     qs;
    logic signed [HEAD_W-1:0]  head_sat;
    logic signed [HEAD_W:0]    hsum;
    logic signed [HEAD_W-1:0]  mid;
    logic [RED_W-1:0]          red_k;
    logic signed [ANG_W-1:0]   a0, a1;
    logic signed [XY_W-1:0]    xs, ys;
    logic signed [XY_W-1:0]    xf, yf;
    logic signed [MUL_A_W-1:0] ma;
    logic signed [MUL_B_W-1:0] mb;
    logic signed [SUM_W-1:0]   half;
    logic signed [SUM_W:0]     sx, sy;
    logic signed [POS_W-1:0]   sat_x, sat_y;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W:0] v);
        logic signed [SUM_W:0] hi, lo;
        hi = (SUM_W+1)'((65'sd1 <<< (POS_W - 1)) - 65'sd1);
        lo = -hi - 1;
        if (v > hi) return POS_W'(hi);
        else if (v < lo) return POS_W'(lo);
        else return POS_W'(v);
    endfunction

    assign w     = (i_track_width == '0) ? 16'd1 : i_track_width;
    assign rem_t = {r_rem, r_num[NUM_W-1]};
    assign ge    = (rem_t >= 18'(w));
    assign qs    = r_neg ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num});
    assign head_sat = (qs > (NUM_W+1)'(64'sd2147483647)) ? 32'sh7fffffff
                    : (qs < -(NUM_W+1)'(64'sd2147483648)) ? 32'sh80000000
                    : HEAD_W'(qs);
    assign hsum  = (HEAD_W+1)'(r_head) + (HEAD_W+1)'(r_prev);
    assign mid   = HEAD_W'(hsum >>> 1);
    assign red_k = ANG_TWO_PI << r_cnt[2:0];
    assign xs    = r_x >>> r_cnt[4:0];
    assign ys    = r_y >>> r_cnt[4:0];
    assign xf    = r_flip ? -r_x : r_x;
    assign yf    = r_flip ? -r_y : r_y;
    assign half  = SUM_W'(1) <<< (RND_SH - 1);
    assign sx    = (SUM_W+1)'(r_acc_x) + (SUM_W+1)'(r_px);
    assign sy    = (SUM_W+1)'(r_acc_y) + (SUM_W+1)'(r_py);
    assign sat_x = sat_pos(sx);
    assign sat_y = sat_pos(sy);

    // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
    always_comb begin
        a0 = r_red_neg ? -$signed(ANG_W'(r_red)) : $signed(ANG_W'(r_red));
        if (a0 > ANG_PI) a0 = a0 - (ANG_PI <<< 1);
        else if (a0 < -ANG_PI) a0 = a0 + (ANG_PI <<< 1);
        a1 = a0;
        if (a0 > ANG_HALF_PI) a1 = a0 - ANG_PI;
        else if (a0 < -ANG_HALF_PI) a1 = a0 + ANG_PI;
    end

    always_comb begin
        unique case (r_cnt[2:0])
            3'd0:    begin ma = r_sum; mb = r_cos; end
            3'd1:    begin ma = r_ds2; mb = r_sin; end
            3'd2:    begin ma = r_sum; mb = r_sin; end
            default: begin ma = r_ds2; mb = r_cos; end
        endcase
    end

    assign o_pop   = (r_st == ST_IDLE) && !i_q_empty;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (!i_q_empty) n_st = ST_DIV;
            ST_DIV:  if (r_cnt == '0) n_st = ST_HEAD;
            ST_HEAD: n_st = ST_MID;
            ST_MID:  n_st = ST_RED;
            ST_RED:  if (r_cnt == '0) n_st = ST_FOLD;
            ST_FOLD: n_st = ST_ROT;
            ST_ROT:  if (r_cnt == 6'(ROT_N - 1)) n_st = ST_CS;
            ST_CS:   n_st = ST_MUL;
            ST_MUL:  if (r_cnt == 6'd4) n_st = ST_RND;
            ST_RND:  n_st = ST_OUT;
            ST_OUT:  if (!r_out_v || i_ready) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else          r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (r_st == ST_MID) r_prev <= r_head;
            if (r_st == ST_OUT && (!r_out_v || i_ready)) begin
                r_acc_x <= sat_x;
                r_acc_y <= sat_y;
                r_out_v <= 1'b1;
            end else if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: begin
                r_sum <= MUL_A_W'(i_tick.dl) + MUL_A_W'(i_tick.dr);
                r_ds2 <= MUL_A_W'(i_tick.ds) <<< 1;
                r_neg <= i_tick.diff < 0;
                r_num <= {(i_tick.diff < 0) ? (DLT_W-1)'(-i_tick.diff)
                                            : (DLT_W-1)'(i_tick.diff), 24'b0};
                r_rem <= '0;
                r_cnt <= 6'(NUM_W - 1);
            end
            ST_DIV: begin
                // shift in one quotient bit a cycle
                r_rem <= ge ? 17'(rem_t - 18'(w)) : rem_t[16:0];
                r_num <= {r_num[NUM_W-2:0], ge};
                r_cnt <= r_cnt - 6'd1;
            end
            ST_HEAD: r_head <= head_sat;
            ST_MID: begin
                r_red_neg <= mid < 0;
                r_red     <= RED_W'(mid < 0 ? -(HEAD_W+1)'(mid) : (HEAD_W+1)'(mid)) << 6;
                r_cnt     <= 6'd4;
            end
            ST_RED: begin
                if (r_red >= red_k) r_red <= r_red - red_k;
                r_cnt <= r_cnt - 6'd1;
            end
            ST_FOLD: begin
                r_ang  <= a1;
                r_flip <= (a1 != a0);
                r_x    <= CORDIC_INV_GAIN;
                r_y    <= '0;
                r_cnt  <= '0;
            end
            ST_ROT: begin
                if (r_ang >= 0) begin
                    r_x   <= r_x - ys;
                    r_y   <= r_y + xs;
                    r_ang <= r_ang - atan_q30(r_cnt[4:0]);
                end else begin
                    r_x   <= r_x + ys;
                    r_y   <= r_y - xs;
                    r_ang <= r_ang + atan_q30(r_cnt[4:0]);
                end
                r_cnt <= r_cnt + 6'd1;
            end
            ST_CS: begin
                r_cos <= MUL_B_W'((xf + XY_W'(2)) >>> 2);
                r_sin <= MUL_B_W'((yf + XY_W'(2)) >>> 2);
                r_cnt <= '0;
            end
            ST_MUL: begin
                // one product a cycle, folded in on the next
                r_prod <= PROD_W'(ma * mb);
                unique case (r_cnt[2:0])
                    3'd1:    r_px <= SUM_W'(r_prod);
                    3'd2:    r_px <= r_px - SUM_W'(r_prod);
                    3'd3:    r_py <= SUM_W'(r_prod);
                    3'd4:    r_py <= r_py + SUM_W'(r_prod);
                    default: ;
                endcase
                r_cnt <= r_cnt + 6'd1;
            end
            ST_RND: begin
                r_px <= (r_px + half) >>> RND_SH;
                r_py <= (r_py + half) >>> RND_SH;
            end
            ST_OUT: begin
                if (!r_out_v || i_ready) r_out <= {r_head, sat_y, sat_x};
            end
            default: ;
        endcase
    end
endmodule

/* bench/drive_odometry_tracker_tb.sv */
// Self-checking bench for the odometry tracker: directed ticks, random ticks, config phases.
module drive_odometry_tracker_tb;
    import dot_pkg::*;

    // laid out as the result word, lowest field last
    typedef struct packed {
        logic signed [31:0] head;
        logic signed [47:0] y;
        logic signed [47:0] x;
    } t_pose;

    typedef struct {
        logic [31:0] l, r, s;
        bit          typed;
        logic [31:0] head;
    } t_tick_row;

    localparam longint TWO_PI_Q30   = 64'sd6746518852;
    localparam longint PI_Q30       = 64'sd3373259426;
    localparam longint HALF_PI_Q30  = 64'sd1686629713;
    localparam longint INV_GAIN_Q30 = 64'sd652032874;
    localparam int     SETTLE       = 200;

    localparam longint ATAN_TBL [28] = '{
        843314857, 497837830, 263043837, 133525159, 67021688, 33543516,
        16775852, 8388438, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
        128, 64, 32, 16, 8
    };

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          i_s_axis_tvalid = 0;
    logic          o_s_axis_tready;
    logic [95:0]   i_s_axis_tdata = '0;   // left_count, right_count, strafe_count
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready = 0;
    logic [127:0]  o_m_axis_tdata;        // pos_x, pos_y, heading_angle
    logic          i_cfg_wr_en = 0;
    logic [1:0]    i_cfg_index = '0;
    logic [15:0]   i_cfg_data = '0;

    drive_odometry_tracker DUT (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // tracker state as the bench sees it
    longint width_reg, enable_reg;
    longint last_l, last_r, last_s, prev_head, acc_x, acc_y;
    t_pose  pose_q[$];
    int     err_cnt = 0;
    bit     typed_on = 0;
    logic [31:0] typed_head = '0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    function automatic longint clip(input longint v, input int bits);
        longint hi;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic void sin_cos(input longint ang24, output longint c, output longint sn);
        longint a, x, y, xs, ys;
        bit     flip;
        a = (ang24 * 64) % TWO_PI_Q30;
        flip = 0;
        x = INV_GAIN_Q30;
        y = 0;
        if (a > PI_Q30) a -= TWO_PI_Q30;
        if (a < -PI_Q30) a += TWO_PI_Q30;
        if (a > HALF_PI_Q30) begin
            a -= PI_Q30;
            flip = 1;
        end else if (a < -HALF_PI_Q30) begin
            a += PI_Q30;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 28; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (a >= 0) begin
                x -= ys; y += xs; a -= ATAN_TBL[i];
            end else begin
                x += ys; y -= xs; a += ATAN_TBL[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = (x + 2) >>> 2;
        sn = (y + 2) >>> 2;
    endfunction

    function automatic t_pose track_tick(input logic [95:0] word);
        longint dl, dr, ds, v, diff, mag, q, head, c, sn, sm, nx, ny, w;
        int     sh;
        t_pose  p;
        dl = 0; dr = 0; ds = 0;
        sh = 29 - POS_FRAC_BITS;
        w = (width_reg == 0) ? 1 : width_reg;
        if (enable_reg[0]) begin
            v = $signed(word[31:0]);
            dl = clip(v - last_l, COUNT_BITS);
            last_l = v;
        end
        if (enable_reg[1]) begin
            v = $signed(word[63:32]);
            dr = clip(v - last_r, COUNT_BITS);
            last_r = v;
        end
        if (enable_reg[2]) begin
            v = $signed(word[95:64]);
            ds = clip(v - last_s, COUNT_BITS);
            last_s = v;
        end
        diff = last_r - last_l;
        mag = diff < 0 ? -diff : diff;
        q = (mag * (64'sd1 <<< 24)) / w;
        if (diff < 0) q = -q;
        head = clip(q, 32);
        // midpoint of old and new heading, rounded down
        sin_cos((head + prev_head) >>> 1, c, sn);
        prev_head = head;
        sm = dl + dr;
        nx = (sm * c - 2 * ds * sn + (64'sd1 <<< (sh - 1))) >>> sh;
        ny = (sm * sn + 2 * ds * c + (64'sd1 <<< (sh - 1))) >>> sh;
        acc_x = clip(acc_x + nx, 48);
        acc_y = clip(acc_y + ny, 48);
        p.x = acc_x[47:0];
        p.y = acc_y[47:0];
        p.head = head[31:0];
        return p;
    endfunction

    // predict on accepted ticks and config writes, check accepted results
    always @(posedge i_clk) begin
        t_pose p, got;
        if (!i_rst_n) begin
            width_reg = 1; enable_reg = 7;
            last_l = 0; last_r = 0; last_s = 0;
            prev_head = 0; acc_x = 0; acc_y = 0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == REG_TRACK_WIDTH) width_reg = i_cfg_data;
                else if (i_cfg_index == REG_ENC_ENABLE) enable_reg = i_cfg_data[2:0];
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                p = track_tick(i_s_axis_tdata);
                if (typed_on && p.head !== typed_head)
                    report("typed heading", p.head, $signed(typed_head));
                pose_q.push_back(p);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata[127:0];
                if (pose_q.size() == 0) begin
                    $display("unexpected result word at %0t", $realtime);
                    err_cnt++;
                end else begin
                    p = pose_q.pop_front();
                    if (got.x !== p.x) report("pos_x", got.x, p.x);
                    if (got.y !== p.y) report("pos_y", got.y, p.y);
                    if (got.head !== p.head) report("heading", got.head, p.head);
                end
            end
        end
    end

    // receiver: alternate between open stretches and random stalls
    int stall_mode = 0, mode_left = 0;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (stall_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: i_m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    int burst_left = 0;

    task automatic send_tick(input logic [31:0] l, r, s, input bit typed, input logic [31:0] h);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {s, r, l};
        typed_on <= typed;
        typed_head <= h;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 150);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                typed_on <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        typed_on <= 1'b0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // hold the write strobe; the caller drops it after the last write
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    t_tick_row tick_rows[] = '{
        '{32'd0, 32'd0, 32'd0, 1, 32'd0},
        '{32'd100, 32'd100, 32'd0, 1, 32'd0},
        '{32'd100, 32'd101, 32'd0, 1, 32'h0100_0000},
        '{32'd100, 32'd99, 32'd5, 1, 32'hFF00_0000},
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1, 32'h8000_0000},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0},
        '{32'd0, 32'd0, 32'd0, 1, 32'd0},
        '{32'd3, 32'd7, 32'hFFFF_FFF0, 0, 32'd0},
        '{32'd40, 32'd60, 32'd20, 0, 32'd0},
        '{32'd80, 32'd50, 32'd20, 0, 32'd0},
        '{32'h1234_5678, 32'hEDCB_A987, 32'h5555_5555, 0, 32'd0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 0, 32'd0}
    };

    logic [31:0] cur_l, cur_r, cur_s;

    function automatic logic [31:0] step(input logic [31:0] v);
        if ($urandom_range(0, 9) == 0) return $urandom;
        return v + 32'($signed($urandom_range(0, 400)) - 200);
    endfunction

    initial begin
        logic [15:0] wv;
        logic [2:0]  ev;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (tick_rows[k])
            send_tick(tick_rows[k].l, tick_rows[k].r, tick_rows[k].s,
                      tick_rows[k].typed, tick_rows[k].head);
        // hold off until every result has come back
        drain();

        cur_l = 0; cur_r = 0; cur_s = 0;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin wv = 16'd0;     ev = 3'd7; end
                1: begin wv = 16'hFFFF;  ev = 3'd0; end
                2: begin wv = 16'd1;     ev = 3'd1; end
                3: begin wv = 16'd500;   ev = 3'd6; end
                default: begin
                    wv = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 2000));
                    ev = $urandom_range(0, 7);
                end
            endcase
            write_reg(REG_TRACK_WIDTH, wv);
            write_reg(REG_ENC_ENABLE, {13'($urandom), ev});
            // unused indexes must leave both registers alone
            write_reg(2'd2, 16'($urandom));
            write_reg(2'd3, 16'($urandom));
            i_cfg_wr_en <= 1'b0;
            for (int n = 0; n < 85; n++) begin
                cur_l = step(cur_l);
                cur_r = step(cur_r);
                cur_s = step(cur_s);
                send_tick(cur_l, cur_r, cur_s, 0, 32'd0);
            end
            drain();
        end

        if (err_cnt == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
